// File: rtl/core/xlb_pkg.sv
`timescale 1ns / 1ps

package xlb_pkg;

    // Basis word width and the slot count that follows from it.
    localparam int WIDTH = 32;
    localparam int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int RANK_W = $clog2(WIDTH + 1);

    // Fixed field widths of the channels.
    localparam int WORD_W = 32;
    localparam int MAX_W = 32;
    localparam int RANK_OUT_W = 6;
    localparam int RANK_OUT_MAX = (1 << RANK_OUT_W) - 1;

    typedef logic [WIDTH-1:0] vec_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [RANK_W-1:0] rank_t;

    typedef struct packed {
        logic we;
        idx_t waddr;
        vec_t wdata;
        idx_t raddr;
    } ram_req_t;

    typedef struct packed {
        vec_t best;
        logic grew;
        rank_t rank;
    } result_t;

endpackage

// File: rtl/core/xlb_in_if.sv
`timescale 1ns / 1ps

interface xlb_in_if;
    import xlb_pkg::*;

    logic valid;
    logic ready;
    logic [WORD_W-1:0] word;
    logic start_set;

    modport source (output valid, output word, output start_set, input ready);
    modport sink (input valid, input word, input start_set, output ready);
endinterface

// File: rtl/core/xlb_out_if.sv
`timescale 1ns / 1ps

interface xlb_out_if;
    import xlb_pkg::*;

    logic valid;
    logic ready;
    logic [MAX_W-1:0] max_subset_xor;
    logic grew;
    logic [RANK_OUT_W-1:0] rank;

    modport source (output valid, output max_subset_xor, output grew, output rank,
                    input ready);
    modport sink (input valid, input max_subset_xor, input grew, input rank,
                  output ready);
endinterface

// File: rtl/core/xlb_basis_ram.sv
`timescale 1ns / 1ps

module xlb_basis_ram (
    input  logic              clk,
    input  xlb_pkg::ram_req_t ram_req,
    output xlb_pkg::vec_t     rdata
);
    import xlb_pkg::*;

    vec_t mem [WIDTH];
    vec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ram_req.we)
        begin
            mem[ram_req.waddr] <= ram_req.wdata;
        end
        rdata_reg <= mem[ram_req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/xlb_reduce.sv
`timescale 1ns / 1ps

module xlb_reduce (
    input  logic              clk,
    input  logic              rst_n,
    xlb_in_if.sink            req,
    output xlb_pkg::ram_req_t ram_req,
    input  xlb_pkg::vec_t     rdata,
    output logic              res_valid,
    input  logic              res_ready,
    output xlb_pkg::result_t  res
);
    import xlb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    idx_t       idx_reg, idx_next;
    vec_t       valid_reg, valid_next;
    rank_t      rank_reg, rank_next;
    vec_t       v_reg, v_next;
    vec_t       best_reg, best_next;
    logic       grew_reg, grew_next;
    vec_t       slot_val;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        valid_next = valid_reg;
        rank_next = rank_reg;
        v_next = v_reg;
        best_next = best_reg;
        grew_next = grew_reg;
        req.ready = 1'b0;
        res_valid = 1'b0;
        ram_req.we = 1'b0;
        ram_req.waddr = idx_reg;
        ram_req.wdata = v_reg;
        ram_req.raddr = idx_reg - idx_t'(1);
        slot_val = valid_reg[idx_reg] ? rdata : '0;

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                ram_req.raddr = idx_t'(WIDTH - 1);
                if (req.valid)
                begin
                    v_next = vec_t'(req.word);
                    best_next = '0;
                    grew_next = 1'b0;
                    idx_next = idx_t'(WIDTH - 1);
                    if (req.start_set)
                    begin
                        valid_next = '0;
                        rank_next = '0;
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // One slot per cycle from the top bit down. The slot written here is
                // never read again for this word, so no forwarding is needed.
                if (v_reg[idx_reg])
                begin
                    if (!valid_reg[idx_reg])
                    begin
                        ram_req.we = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                        rank_next = rank_reg + rank_t'(1);
                        grew_next = 1'b1;
                        slot_val = v_reg;
                        v_next = '0;
                    end
                    else
                    begin
                        v_next = v_reg ^ slot_val;
                    end
                end
                // Greedy maximum: a slot's top bit is its index.
                if (!best_reg[idx_reg])
                begin
                    best_next = best_reg ^ slot_val;
                end
                if (idx_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg - idx_t'(1);
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            valid_reg <= '0;
            rank_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            valid_reg <= valid_next;
            rank_reg <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        best_reg <= best_next;
        grew_reg <= grew_next;
    end

    assign res.best = best_reg;
    assign res.grew = grew_reg;
    assign res.rank = rank_reg;

endmodule

// File: rtl/core/xor_linear_basis_unit.sv
`timescale 1ns / 1ps

// Linear basis over GF(2): each word on req is reduced against the stored
// vectors, from the top bit down, and stored in the empty slot of its leading
// bit or dropped if it reduces to zero. A set start_set empties the basis first.
// Every req transfer yields exactly one rsp transfer carrying the largest XOR
// of any subset of the current set, whether the word was stored, and the rank.
// The basis sits in a one-read, one-write memory with one slot per bit; the
// block walks it one slot per cycle, inserting and building the maximum in the
// same pass. A word is taken in the idle state, the walk runs over the memory
// from the top slot down, the done state hands the result to the output
// register, and the block then goes back to idle to take the next word; it
// takes no new word before its result has been handed to the output register.
// A finished result waits in an output register, so the next word is taken
// while rsp is stalled; a second result waits inside until the register frees.
// Reset empties the basis at once through per-slot occupancy bits; the memory
// itself needs no clearing pass.
module xor_linear_basis_unit (
    input  logic    clk,
    input  logic    rst_n,
    xlb_in_if.sink  req,
    xlb_out_if.source rsp
);
    import xlb_pkg::*;

    ram_req_t ram_req;
    vec_t     rdata;
    logic     res_valid;
    logic     res_ready;
    result_t  res;

    logic                  out_valid_reg;
    logic [MAX_W-1:0]      max_reg;
    logic                  grew_reg;
    logic [RANK_OUT_W-1:0] rank_reg;

    xlb_basis_ram u_ram (
        .clk     (clk),
        .ram_req (ram_req),
        .rdata   (rdata)
    );

    xlb_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ram_req   (ram_req),
        .rdata     (rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            max_reg <= MAX_W'(res.best);
            grew_reg <= res.grew;
            if (int'(res.rank) > RANK_OUT_MAX)
            begin
                rank_reg <= RANK_OUT_W'(RANK_OUT_MAX);
            end
            else
            begin
                rank_reg <= RANK_OUT_W'(res.rank);
            end
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.max_subset_xor = max_reg;
    assign rsp.grew = grew_reg;
    assign rsp.rank = rank_reg;

endmodule

// File: tb/xlb_basis_checker.sv
`timescale 1ns / 1ps

module xlb_basis_checker (
    input  logic clk,
    input  logic rst_n,
    xlb_in_if    req,
    xlb_out_if   rsp,
    output int   mismatches,
    output int   pending,
    output int   results_checked,
    output int   full_rank_hits
);
    import xlb_pkg::*;

    typedef struct packed {
        logic [MAX_W-1:0]      max_xor;
        logic                  grew;
        logic [RANK_OUT_W-1:0] rank;
    } basis_report_t;

    vec_t          slots [WIDTH];
    basis_report_t expected_reports [$];

    // Inserts one word into the shadow basis and returns the report the block
    // should give for it.
    function automatic basis_report_t insert_word(input logic [WORD_W-1:0] w,
                                                  input logic start);
        basis_report_t rep;
        vec_t          v;
        vec_t          best;
        vec_t          cand;
        int            rank_count;
        rep = '0;
        best = '0;
        rank_count = 0;
        v = vec_t'(w);
        if (start)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                slots[i] = '0;
            end
        end
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                if (slots[i] == '0)
                begin
                    slots[i] = v;
                    rep.grew = 1'b1;
                    v = '0;
                end
                else
                begin
                    v ^= slots[i];
                end
            end
        end
        // Greedy walk from the top slot: taking a slot only when it raises the
        // running value gives the largest subset XOR.
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            cand = best ^ slots[i];
            if (cand > best)
            begin
                best = cand;
            end
            if (slots[i] != '0)
            begin
                rank_count++;
            end
        end
        if (rank_count > RANK_OUT_MAX)
        begin
            rank_count = RANK_OUT_MAX;
        end
        rep.max_xor = MAX_W'(best);
        rep.rank = RANK_OUT_W'(rank_count);
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        basis_report_t want;
        int            errs;
        if (!rst_n)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                slots[i] = '0;
            end
            expected_reports.delete();
            mismatches <= 0;
            pending <= 0;
            results_checked <= 0;
            full_rank_hits <= 0;
        end
        else
        begin
            errs = 0;
            if (rsp.valid && rsp.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t ns: result with nothing expected, got max %h grew %b rank %0d",
                             $time, rsp.max_subset_xor, rsp.grew, rsp.rank);
                    errs++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (rsp.max_subset_xor !== want.max_xor)
                    begin
                        $display("%0t ns: max_subset_xor expected %h, got %h",
                                 $time, want.max_xor, rsp.max_subset_xor);
                        errs++;
                    end
                    if (rsp.grew !== want.grew)
                    begin
                        $display("%0t ns: grew expected %b, got %b",
                                 $time, want.grew, rsp.grew);
                        errs++;
                    end
                    if (rsp.rank !== want.rank)
                    begin
                        $display("%0t ns: rank expected %0d, got %0d",
                                 $time, want.rank, rsp.rank);
                        errs++;
                    end
                    if (want.rank == RANK_OUT_W'(WIDTH))
                    begin
                        full_rank_hits <= full_rank_hits + 1;
                    end
                end
                results_checked <= results_checked + 1;
            end
            if (req.valid && req.ready)
            begin
                expected_reports.push_back(insert_word(req.word, req.start_set));
            end
            mismatches <= mismatches + errs;
            pending <= expected_reports.size();
        end
    end

endmodule

// File: tb/tb_xor_linear_basis_unit.sv
`timescale 1ns / 1ps

module tb_xor_linear_basis_unit;
    import xlb_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int RESET_CYCLES = 10;
    localparam int TOTAL_WORDS = 1600;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = WIDTH + 8;
    localparam int CALM_FIRST = 700;
    localparam int CALM_LAST = 1000;

    typedef enum int {MIX_SET, FILL_SET, LOW_SET, NOISE_SET} set_kind_e;
    typedef enum int {RAND_WORD, SPARSE_WORD, DEP_WORD, ZERO_WORD} word_kind_e;

    logic clk;
    logic rst_n;

    xlb_in_if  req_ch ();
    xlb_out_if rsp_ch ();

    int mismatches;
    int pending;
    int results_checked;
    int full_rank_hits;
    int words_sent;
    int sets_started;
    int quiet_cycles;
    bit calm;

    // Words of the current set, used to build words that are known to be
    // dependent on it.
    logic [WORD_W-1:0] set_words [$];

    xor_linear_basis_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    xlb_basis_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .full_rank_hits  (full_rank_hits)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // Ends the run when no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transfer", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: mostly ready, with short stalls and now and then a long one.
    initial
    begin
        int hold;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold == 0 && !calm)
            begin
                if ($urandom_range(999) == 0)
                begin
                    hold = $urandom_range(40, 80);
                end
                else if ($urandom_range(99) < 4)
                begin
                    hold = 1;
                end
            end
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic [WORD_W-1:0] w, input logic s);
        int gap;
        calm = (words_sent >= CALM_FIRST && words_sent < CALM_LAST);
        if (!calm && $urandom_range(99) < 6)
        begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.word <= w;
        req_ch.start_set <= s;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (s)
        begin
            sets_started++;
            set_words.delete();
        end
        set_words.push_back(w);
    endtask

    function automatic logic [WORD_W-1:0] make_word(input word_kind_e kind);
        logic [WORD_W-1:0] acc;
        acc = '0;
        case (kind)
            RAND_WORD:
            begin
                acc = $urandom;
            end
            SPARSE_WORD:
            begin
                repeat ($urandom_range(1, 3)) acc[$urandom_range(WORD_W - 1)] = 1'b1;
            end
            DEP_WORD:
            begin
                foreach (set_words[k])
                begin
                    if ($urandom_range(1))
                    begin
                        acc ^= set_words[k];
                    end
                end
            end
            default:
            begin
                acc = '0;
            end
        endcase
        return acc;
    endfunction

    function automatic word_kind_e pick_kind();
        int r;
        r = $urandom_range(9);
        if (r < 4)
        begin
            return RAND_WORD;
        end
        if (r < 6)
        begin
            return SPARSE_WORD;
        end
        if (r < 9)
        begin
            return DEP_WORD;
        end
        return ZERO_WORD;
    endfunction

    initial
    begin
        set_kind_e         kind;
        int                r;
        int                len;
        int                fill_bit;
        logic [WORD_W-1:0] one;
        logic [WORD_W-1:0] w;
        logic              s;

        one = 1;
        words_sent = 0;
        sets_started = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.word <= '0;
        req_ch.start_set <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero words on an empty and on a filled basis, the extreme
        // words, dependent words, and a start flag carrying a zero word.
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h7FFF_FFFE, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'h0000_0001, 1'b1);
        send_word(32'h0000_0002, 1'b0);
        send_word(32'h0000_0003, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b1);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h4000_0000, 1'b0);
        send_word(32'hC000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h1234_5678, 1'b1);
        send_word(32'h1234_5678, 1'b1);
        send_word(32'h0000_0000, 1'b1);

        while (words_sent < TOTAL_WORDS)
        begin
            r = $urandom_range(9);
            if (r < 3)
            begin
                kind = FILL_SET;
            end
            else if (r == 3)
            begin
                kind = LOW_SET;
            end
            else if (r < 9)
            begin
                kind = MIX_SET;
            end
            else
            begin
                kind = NOISE_SET;
            end
            len = (kind == FILL_SET) ? $urandom_range(34, 45) :
                  (kind == NOISE_SET) ? $urandom_range(1, 3) : $urandom_range(1, 45);
            fill_bit = WORD_W - 1;
            for (int n = 0; n < len; n++)
            begin
                s = (n == 0) ? ($urandom_range(9) != 0) : 1'b0;
                case (kind)
                    FILL_SET:
                    begin
                        // Descending leading bits build a basis up to full rank.
                        if (fill_bit >= 0 && $urandom_range(7) != 0)
                        begin
                            w = (one << fill_bit) | ($urandom & ((one << fill_bit) - one));
                            fill_bit--;
                        end
                        else
                        begin
                            w = make_word(DEP_WORD);
                        end
                    end
                    LOW_SET:
                    begin
                        w = make_word(pick_kind()) & 32'h0000_00FF;
                    end
                    NOISE_SET:
                    begin
                        s = 1'($urandom_range(1));
                        w = make_word(pick_kind());
                    end
                    default:
                    begin
                        w = make_word(pick_kind());
                    end
                endcase
                send_word(w, s);
            end
        end
        req_ch.valid <= 1'b0;

        // The count of results in flight is updated at the edge of the last
        // transfer, so it is read only from the next edge on.
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Inserted %0d words over %0d new sets; %0d results checked.",
                 words_sent, sets_started, results_checked);
        $display("A full basis of %0d vectors was reported %0d times.", WIDTH, full_rank_hits);
        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
